[rtl/pkoq_pkg.sv]
// Package: shared types and codes for the per-key order queue.
`default_nettype none
package pkoq_pkg;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CHECK   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNKNOWN    = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               is_extract;
    logic               is_packing;
    logic [15:0]        unit_number;
    logic signed [31:0] port_offset;
    logic [63:0]        op_id;
  } in_item_t;

  typedef struct packed {
    logic       may_issue;
    logic [1:0] status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the accepted item
    logic lookup;  // register key match and free slot
    logic alloc;   // take the free slot for a new key
    logic append;  // append to the matched queue
    logic read;    // read the head entry of the matched queue
    logic pop;     // pop the head of the matched queue
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       ordered;
    logic [1:0] cmd;
    logic       hit;
    logic       free_ok;
    logic       full;
    logic       match;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/pkoq_datapath.sv]
// Datapath: key table, per-slot queue pointers and the queue memory.
`default_nettype none
module pkoq_datapath #(
  parameter int NUM_KEYS    = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire pkoq_pkg::in_item_t in_item_i,
  input  wire pkoq_pkg::dp_cmd_t  cmd_i,
  output pkoq_pkg::dp_stat_t      stat_o
);
  import pkoq_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = QW + 2;
  localparam int MEM_DEPTH = NUM_KEYS * (2 ** QW);

  in_item_t item_q;

  logic            valid_q [NUM_KEYS];
  logic [15:0]     unit_q  [NUM_KEYS];
  logic [31:0]     off_q   [NUM_KEYS];
  logic [QW-1:0]   head_q  [NUM_KEYS];
  logic [CW-1:0]   count_q [NUM_KEYS];

  logic [63:0]     mem [MEM_DEPTH];
  logic [63:0]     rdata_q;

  logic            hit_q, free_ok_q;
  logic [KW-1:0]   slot_q, free_q;

  logic            hit_d, free_ok_d;
  logic [KW-1:0]   slot_d, free_d;

  logic [QW-1:0]   head_sel;
  logic [CW-1:0]   count_sel;
  logic [QW-1:0]   tail;
  logic [QW-1:0]   head_next;

  // circular index: a + b where the sum stays below twice the depth
  function automatic logic [QW-1:0] wrap_add(logic [QW-1:0] a, logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[QW-1:0];
  endfunction

  // parallel key compare and lowest free slot
  always_comb begin
    hit_d     = 1'b0;
    slot_d    = '0;
    free_ok_d = 1'b0;
    free_d    = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (valid_q[i] && unit_q[i] == item_q.unit_number &&
          off_q[i] == item_q.port_offset) begin
        hit_d  = 1'b1;
        slot_d = KW'(i);
      end
      if (!valid_q[i]) begin
        free_ok_d = 1'b1;
        free_d    = KW'(i);
      end
    end
  end

  assign head_sel  = head_q[slot_q];
  assign count_sel = count_q[slot_q];
  assign tail      = wrap_add(head_sel, count_sel);
  assign head_next = wrap_add(head_sel, CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.lookup) begin
      slot_q <= slot_d;
      free_q <= free_d;
    end
    if (cmd_i.alloc) begin
      unit_q[free_q] <= item_q.unit_number;
      off_q[free_q]  <= item_q.port_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        valid_q[i] <= 1'b0;
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cmd_i.lookup) begin
        hit_q     <= hit_d;
        free_ok_q <= free_ok_d;
      end
      if (cmd_i.alloc) begin
        valid_q[free_q] <= 1'b1;
        head_q[free_q]  <= '0;
        count_q[free_q] <= CW'(1);
      end
      if (cmd_i.append) count_q[slot_q] <= count_sel + CW'(1);
      if (cmd_i.pop) begin
        count_q[slot_q] <= count_sel - CW'(1);
        if (count_sel == CW'(1)) begin
          valid_q[slot_q] <= 1'b0;
          head_q[slot_q]  <= '0;
        end else begin
          head_q[slot_q] <= head_next;
        end
      end
    end
  end

  // queue memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) mem[{free_q, QW'(0)}] <= item_q.op_id;
    else if (cmd_i.append) mem[{slot_q, tail}] <= item_q.op_id;
    if (cmd_i.read) rdata_q <= mem[{slot_q, head_sel}];
  end

  assign stat_o.ordered = item_q.is_extract | item_q.is_packing;
  assign stat_o.cmd     = item_q.cmd;
  assign stat_o.hit     = hit_q;
  assign stat_o.free_ok = free_ok_q;
  assign stat_o.full    = (count_sel == CW'(QUEUE_DEPTH));
  assign stat_o.match   = (rdata_q == item_q.op_id);

endmodule
`default_nettype wire

[rtl/pkoq_ctrl.sv]
// Controller: sequencing state machine and result register.
`default_nettype none
module pkoq_ctrl (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire                 logic out_stall_i,
  output pkoq_pkg::out_item_t       out_item_o,
  output pkoq_pkg::dp_cmd_t         cmd_o,
  input  wire pkoq_pkg::dp_stat_t   stat_i
);
  import pkoq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EXEC = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e    state_q, state_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        res_d   = '{may_issue: 1'b0, status: ST_OK};
        state_d = S_DONE;
        if (!stat_i.ordered) begin
          res_d.may_issue = 1'b1;
        end else begin
          case (stat_i.cmd)
            CMD_ADD: begin
              if (!stat_i.hit) begin
                if (stat_i.free_ok) begin
                  cmd_o.alloc     = 1'b1;
                  res_d.may_issue = 1'b1;
                end else begin
                  res_d.status = ST_TABLE_FULL;
                end
              end else if (stat_i.full) begin
                res_d.status = ST_QUEUE_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            CMD_CHECK, CMD_RELEASE: begin
              if (!stat_i.hit) begin
                res_d.status = ST_UNKNOWN;
              end else begin
                cmd_o.read = 1'b1;
                state_d    = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_CMP: begin
        if (stat_i.match) begin
          res_d.may_issue = 1'b1;
          cmd_o.pop       = (stat_i.cmd == CMD_RELEASE);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

[rtl/per_key_order_queue_core.sv]
// Top level: per-key in-order queue of operation IDs.
//
// Input channel: in_valid_i / in_stall_o carry one in_item_t per transfer
// (cmd, ordering flags, key = unit_number + port_offset, op_id).
// Output channel: out_valid_o / out_stall_i carry one out_item_t per input
// item (may_issue, status).
// One item is worked at a time. Add, unordered and error cases pass through
// the lookup, execute and done states from input transfer to out_valid_o;
// check and release add a compare state for the registered read of the
// queue head from the queue memory. The next item is taken the cycle after
// the result is loaded; no new item is taken before the last one is through.
// Key lookup is a parallel exact compare over all key slots.
// A stalled result holds in the output register; the controller waits in
// its final state until the register frees, and in_stall_o stays high.
// Reset clears the slot valid bits, head and count pointers; the queue
// memory and key fields need no clearing, so no sweep follows reset.
`default_nettype none
module per_key_order_queue_core #(
  parameter int NUM_KEYS    = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output logic                      in_stall_o,
  input  wire pkoq_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire                 logic out_stall_i,
  output pkoq_pkg::out_item_t       out_item_o
);
  import pkoq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  pkoq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  pkoq_datapath #(
    .NUM_KEYS    (NUM_KEYS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat)
  );

  // one item in flight: input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // error statuses never grant issue
  a_err_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |-> !out_item_o.may_issue)
    else $error("may_issue set with error status");

  // datapath update commands are exclusive
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.alloc, dp_cmd.append, dp_cmd.read, dp_cmd.pop}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire
